@@ rtl/core/lzc_pkg.sv @@
// Shared constants and types of the LZSS compressor.
// No dependencies; used by every module of the block.
package lzc_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int MAX_MATCH_DEF   = 18;
    localparam int MIN_CODED       = 2;
    localparam int GROUP_TOKENS    = 8;
    localparam int OFF_W           = 12;
    localparam logic [7:0] FILL_RESET = 8'd32;

    // Per-cycle control from the sequencer to the match unit.
    typedef struct packed {
        logic start;   // clear the best match before a new scan
        logic dvalid;  // a window byte arrives this cycle
        logic eval;    // the taps now hold a full candidate position
    } t_scan_ctl;

endpackage

@@ rtl/core/lzss_compressor.sv @@
// LZSS compressor top level: sequencer, lookahead, token group and output register.
// Depends on lzc_pkg, lzc_window and lzc_match.
//
//  channel | valid / ready            | payload
//  --------+--------------------------+----------------------------------------
//  input   | i_s_tvalid / o_s_tready  | i_s_tdata = in_byte, i_s_tlast = in_last
//  output  | o_m_tvalid / i_m_tready  | o_m_tdata = out_byte, o_m_tlast = run_last,
//          |                          | o_m_tuser = stream_done
//  config  | i_cfg_valid / o_cfg_ready| i_cfg_data = window_fill_byte
//
// Every token costs one scan of the window through its single read port, then
// the consuming of its bytes (at most MAX_MATCH); each byte of a group is sent
// when the group goes out. A byte that only fills the lookahead costs no scan.
// After reset and after each end mark, a clearing pass writes the fill byte into
// the whole window, during which no input beat is taken.
// The output register holds a byte while the sink stalls; the sequencer waits for it.
module lzss_compressor #(
    parameter int WINDOW_SIZE = lzc_pkg::WINDOW_SIZE_DEF,
    parameter int MAX_MATCH   = lzc_pkg::MAX_MATCH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // out_byte
    output logic       o_m_tlast,
    output logic       o_m_tuser,   // stream_done
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int LW = $clog2(MAX_MATCH + 1);
    localparam int LI = $clog2(MAX_MATCH);
    localparam int IW = $clog2(WINDOW_SIZE + MAX_MATCH);
    localparam logic [IW-1:0] IDX_END  = IW'(WINDOW_SIZE + MAX_MATCH - 2);
    localparam logic [IW-1:0] IDX_EVAL = IW'(MAX_MATCH - 1);
    localparam logic [IW-1:0] IDX_WRAP = IW'(WINDOW_SIZE);
    localparam logic [AW-1:0] WPOS_RST = AW'(WINDOW_SIZE - MAX_MATCH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW_SIZE - 1);
    localparam logic [LW-1:0] LA_FULL  = LW'(MAX_MATCH);
    localparam logic [LW-1:0] LEN_CODED = LW'(lzc_pkg::MIN_CODED);
    localparam logic [3:0]    GRP_FULL = 4'(lzc_pkg::GROUP_TOKENS);

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_SCAN    = 7'b0000100,
        S_DECIDE  = 7'b0001000,
        S_CONSUME = 7'b0010000,
        S_FLAG    = 7'b0100000,
        S_TOK     = 7'b1000000
    } t_state;

    t_state        r_state;
    logic [7:0]    r_fill;
    logic [7:0]    r_clr_fill;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_wpos;
    logic [7:0]    r_la [MAX_MATCH];
    logic [LW-1:0] r_la_cnt;
    logic          r_last;
    logic [IW-1:0] r_idx;
    logic          r_issue;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [LW-1:0] r_rem;
    logic [7:0]    r_grp [16];
    logic [7:0]    r_marks;
    logic [3:0]    r_tok;
    logic [2:0]    r_ft;
    logic          r_fh;
    logic          r_final;
    logic          r_ovalid;
    logic [7:0]    r_odata;
    logic          r_olast;
    logic          r_odone;

    logic              s_acc;
    logic              can_load;
    logic              cons_go;
    logic              tok_end;
    logic [2:0]        slot;
    logic [AW-1:0]     raddr;
    logic              win_we;
    logic [AW-1:0]     win_waddr;
    logic [7:0]        win_wdata;
    logic [7:0]        rdata;
    lzc_pkg::t_scan_ctl scan_ctl;
    logic [AW-1:0]     best_pos;
    logic [LW-1:0]     best_len;
    logic [lzc_pkg::OFF_W-1:0] off;
    logic [LW-1:0]     len_code;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign can_load   = !r_ovalid || i_m_tready;
    assign cons_go    = (r_rem != '0) && (r_la_cnt != '0);
    assign slot       = r_tok[2:0];
    assign tok_end    = (r_ft == 3'(r_tok - 4'd1)) && (r_fh || r_marks[r_ft]);
    assign off        = lzc_pkg::OFF_W'(best_pos);
    assign len_code   = best_len - LEN_CODED - LW'(1);

    assign raddr = (r_idx >= IDX_WRAP) ? AW'(r_idx - IDX_WRAP) : AW'(r_idx);

    always_comb begin
        win_we    = 1'b0;
        win_waddr = r_wpos;
        win_wdata = r_la[0];
        unique case (r_state)
            S_CLEAR: begin
                win_we    = 1'b1;
                win_waddr = r_clr;
                win_wdata = r_clr_fill;
            end
            S_CONSUME: begin
                win_we = cons_go;
            end
            default: begin
                win_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        scan_ctl.start  = (r_state == S_SCAN) && r_issue && (r_idx == '0);
        scan_ctl.dvalid = r_rd_vld;
        scan_ctl.eval   = r_rd_vld && (r_rd_idx >= IDX_EVAL);
    end

    lzc_window #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (win_wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lzc_match #(
        .WINDOW_SIZE(WINDOW_SIZE),
        .MAX_MATCH  (MAX_MATCH)
    ) u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_data     (rdata),
        .i_pos      (AW'(r_rd_idx - IDX_EVAL)),
        .i_la       (r_la),
        .i_la_cnt   (r_la_cnt),
        .o_best_pos (best_pos),
        .o_best_len (best_len)
    );

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_fill     <= lzc_pkg::FILL_RESET;
            r_clr_fill <= lzc_pkg::FILL_RESET;
            r_clr      <= '0;
            r_wpos     <= WPOS_RST;
            r_la_cnt   <= '0;
            r_last     <= 1'b0;
            r_idx      <= '0;
            r_issue    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_idx   <= '0;
            r_rem      <= '0;
            r_marks    <= '0;
            r_tok      <= '0;
            r_ft       <= '0;
            r_fh       <= 1'b0;
            r_final    <= 1'b0;
            r_ovalid   <= 1'b0;
            r_olast    <= 1'b0;
            r_odone    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_fill <= i_cfg_data;
            end
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            r_rd_vld <= (r_state == S_SCAN) && r_issue;
            r_rd_idx <= r_idx;

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == ADDR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_la_cnt <= r_la_cnt + LW'(1);
                        r_last   <= i_s_tlast;
                        if (i_s_tlast || (r_la_cnt + LW'(1) == LA_FULL)) begin
                            r_state <= S_SCAN;
                            r_idx   <= '0;
                            r_issue <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        r_idx <= r_idx + IW'(1);
                        if (r_idx == IDX_END) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_rd_vld && (r_rd_idx == IDX_END)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (best_len > LEN_CODED) begin
                        r_rem <= best_len;
                    end else begin
                        r_rem   <= LW'(1);
                        r_marks <= r_marks | (8'd1 << slot);
                    end
                    r_tok   <= {1'b0, slot} + 4'd1;
                    r_state <= S_CONSUME;
                end
                S_CONSUME: begin
                    if (cons_go) begin
                        r_wpos   <= (r_wpos == ADDR_LAST) ? '0 : r_wpos + AW'(1);
                        r_la_cnt <= r_la_cnt - LW'(1);
                        r_rem    <= r_rem - LW'(1);
                    end else if (r_tok == GRP_FULL) begin
                        r_state <= S_FLAG;
                        r_final <= !r_last || (r_la_cnt == '0);
                    end else if (r_last && (r_la_cnt != '0)) begin
                        r_state <= S_SCAN;
                        r_idx   <= '0;
                        r_issue <= 1'b1;
                    end else if (r_last) begin
                        r_state <= S_FLAG;
                        r_final <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FLAG: begin
                    if (can_load) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= 1'b0;
                        r_odone  <= 1'b0;
                        r_ft     <= '0;
                        r_fh     <= 1'b0;
                        r_state  <= S_TOK;
                    end
                end
                S_TOK: begin
                    if (can_load) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= tok_end && r_final;
                        r_odone  <= tok_end && r_final && r_last;
                        if (!r_fh && !r_marks[r_ft]) begin
                            r_fh <= 1'b1;
                        end else begin
                            r_fh <= 1'b0;
                            r_ft <= r_ft + 3'd1;
                        end
                        if (tok_end) begin
                            r_marks <= '0;
                            r_tok   <= '0;
                            if (!r_final) begin
                                r_state <= S_SCAN;
                                r_idx   <= '0;
                                r_issue <= 1'b1;
                            end else if (r_last) begin
                                // End of stream: start over with a fresh window.
                                r_state    <= S_CLEAR;
                                r_clr      <= '0;
                                r_clr_fill <= r_fill;
                                r_wpos     <= WPOS_RST;
                                r_last     <= 1'b0;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // Payload registers: lookahead, token group and output byte.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_la[r_la_cnt[LI-1:0]] <= i_s_tdata;
        end
        if ((r_state == S_CONSUME) && cons_go) begin
            for (int j = 0; j < MAX_MATCH - 1; j++) begin
                r_la[j] <= r_la[j+1];
            end
        end
        if (r_state == S_DECIDE) begin
            if (best_len > LEN_CODED) begin
                r_grp[{slot, 1'b0}] <= off[7:0];
                r_grp[{slot, 1'b1}] <= {off[11:8], 4'(len_code)};
            end else begin
                r_grp[{slot, 1'b0}] <= r_la[0];
            end
        end
        if ((r_state == S_FLAG) && can_load) begin
            r_odata <= r_marks;
        end
        if ((r_state == S_TOK) && can_load) begin
            r_odata <= r_grp[{r_ft, r_fh}];
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_odone;

endmodule

@@ rtl/core/lzc_window.sv @@
// Sliding window memory of the LZSS compressor: one write and one read port.
// Depends on lzc_pkg for the default of its parameter.
module lzc_window #(
    parameter int WINDOW_SIZE = lzc_pkg::WINDOW_SIZE_DEF,
    localparam int AW = $clog2(WINDOW_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [WINDOW_SIZE];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/lzc_match.sv @@
// Match unit: holds the last window bytes read, compares them with the lookahead
// and keeps the longest match seen in the scan. Depends on lzc_pkg.
module lzc_match #(
    parameter int WINDOW_SIZE = lzc_pkg::WINDOW_SIZE_DEF,
    parameter int MAX_MATCH   = lzc_pkg::MAX_MATCH_DEF,
    localparam int AW = $clog2(WINDOW_SIZE),
    localparam int LW = $clog2(MAX_MATCH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lzc_pkg::t_scan_ctl i_ctl,
    input  logic [7:0]        i_data,
    input  logic [AW-1:0]     i_pos,
    input  logic [7:0]        i_la [MAX_MATCH],
    input  logic [LW-1:0]     i_la_cnt,
    output logic [AW-1:0]     o_best_pos,
    output logic [LW-1:0]     o_best_len
);

    logic [7:0]    r_tap [MAX_MATCH-1];
    logic [7:0]    cand [MAX_MATCH];
    logic [LW-1:0] len;
    logic          run;
    logic [AW-1:0] r_best_pos;
    logic [LW-1:0] r_best_len;

    always_comb begin
        for (int j = 0; j < MAX_MATCH - 1; j++) begin
            cand[j] = r_tap[j];
        end
        cand[MAX_MATCH-1] = i_data;
    end

    // Length of the run of equal bytes from the front, limited to the fill.
    always_comb begin
        run = 1'b1;
        len = '0;
        for (int j = 0; j < MAX_MATCH; j++) begin
            if (run && (LW'(j) < i_la_cnt) && (cand[j] == i_la[j])) begin
                len = len + LW'(1);
            end else begin
                run = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.dvalid) begin
            for (int j = 0; j < MAX_MATCH - 2; j++) begin
                r_tap[j] <= r_tap[j+1];
            end
            r_tap[MAX_MATCH-2] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_len <= '0;
            r_best_pos <= '0;
        end else if (i_ctl.start) begin
            r_best_len <= '0;
            r_best_pos <= '0;
        end else if (i_ctl.eval && (len > r_best_len)) begin
            r_best_len <= len;
            r_best_pos <= i_pos;
        end
    end

    assign o_best_pos = r_best_pos;
    assign o_best_len = r_best_len;

endmodule

@@ bench/lzss_checker.sv @@
// Checker for the LZSS compressor: watches the input, output and configuration channels,
// predicts the compressed stream and compares it beat by beat. Depends on lzc_pkg only.
`timescale 1ns / 100ps
module lzss_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,
    input  logic       i_m_tlast,
    input  logic       i_m_tuser,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int WIN = lzc_pkg::WINDOW_SIZE_DEF;
    localparam int LA  = lzc_pkg::MAX_MATCH_DEF;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       done;
    } t_coded_byte;

    t_coded_byte coded_fifo[$];
    t_coded_byte step_bytes[$];

    int          fail_cnt = 0;
    logic [7:0]  fill_byte;
    logic [7:0]  window_mem [WIN];
    logic [11:0] wr_pos;
    logic [7:0]  look [LA];
    int          look_head;
    int          look_cnt;
    logic [7:0]  group_mem [2*lzc_pkg::GROUP_TOKENS];
    logic [7:0]  literal_marks;
    int          token_cnt;

    assign o_fail_count = fail_cnt;

    task automatic restart_stream();
        for (int i = 0; i < WIN; i++) window_mem[i] = fill_byte;
        wr_pos = 12'(WIN - LA);
        look_head = 0;
        look_cnt = 0;
        literal_marks = '0;
        token_cnt = 0;
    endtask

    task automatic emit_group();
        step_bytes.push_back({literal_marks, 1'b0, 1'b0});
        for (int t = 0; t < token_cnt; t++) begin
            step_bytes.push_back({group_mem[2*t], 1'b0, 1'b0});
            if (!literal_marks[t]) step_bytes.push_back({group_mem[2*t+1], 1'b0, 1'b0});
        end
        literal_marks = '0;
        token_cnt = 0;
    endtask

    task automatic retire_bytes(int len);
        for (int k = 0; k < len && look_cnt > 0; k++) begin
            window_mem[wr_pos] = look[look_head];
            wr_pos = wr_pos + 12'd1;
            look_head = (look_head + 1) % LA;
            look_cnt--;
        end
    endtask

    // Longest match over the whole window; a strictly longer match is needed to
    // replace an earlier position, so the lowest offset wins ties.
    task automatic encode_next_token();
        int best_pos;
        int best_len;
        int len;
        best_pos = 0;
        best_len = 0;
        for (int p = 0; p < WIN; p++) begin
            len = 0;
            while (len < look_cnt &&
                   window_mem[(p + len) % WIN] == look[(look_head + len) % LA])
                len++;
            if (len > best_len) begin
                best_pos = p;
                best_len = len;
            end
        end
        if (best_len > lzc_pkg::MIN_CODED) begin
            group_mem[2*token_cnt]   = best_pos[7:0];
            group_mem[2*token_cnt+1] = {best_pos[11:8],
                                        4'(best_len - lzc_pkg::MIN_CODED - 1)};
            retire_bytes(best_len);
        end else begin
            group_mem[2*token_cnt] = look[look_head];
            literal_marks[token_cnt] = 1'b1;
            retire_bytes(1);
        end
        token_cnt++;
        if (token_cnt == lzc_pkg::GROUP_TOKENS) emit_group();
    endtask

    task automatic accept_plain_byte(logic [7:0] b, logic is_last);
        step_bytes.delete();
        if (look_cnt < LA) begin
            look[(look_head + look_cnt) % LA] = b;
            look_cnt++;
        end
        if (is_last) begin
            while (look_cnt > 0) encode_next_token();
            if (token_cnt > 0) emit_group();
        end else if (look_cnt >= LA) begin
            encode_next_token();
        end
        if (step_bytes.size() > 0) begin
            step_bytes[step_bytes.size()-1].run_last = 1'b1;
            step_bytes[step_bytes.size()-1].done = is_last;
        end
        foreach (step_bytes[i]) coded_fifo.push_back(step_bytes[i]);
        if (is_last) restart_stream();
    endtask

    always @(posedge i_clk) begin
        t_coded_byte exp_b;
        if (!i_rst_n) begin
            fill_byte = lzc_pkg::FILL_RESET;
            restart_stream();
            coded_fifo.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) fill_byte = i_cfg_data;
            if (i_s_tvalid && i_s_tready) accept_plain_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (coded_fifo.size() == 0) begin
                    $display("%0t: unexpected output beat data=%02h last=%b done=%b",
                             $time, i_m_tdata, i_m_tlast, i_m_tuser);
                    fail_cnt++;
                end else begin
                    exp_b = coded_fifo.pop_front();
                    if (exp_b.data !== i_m_tdata || exp_b.run_last !== i_m_tlast ||
                        exp_b.done !== i_m_tuser) begin
                        $display({"%0t: mismatch expected data=%02h last=%b done=%b,",
                                  " got data=%02h last=%b done=%b"},
                                 $time, exp_b.data, exp_b.run_last, exp_b.done,
                                 i_m_tdata, i_m_tlast, i_m_tuser);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending = coded_fifo.size();
    end
endmodule

@@ bench/tb_top.sv @@
// Testbench top for the LZSS compressor: clock, reset, stimulus and verdict.
// Depends on lzc_pkg, lzss_compressor and lzss_checker.
`timescale 1ns / 100ps
module tb_top;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = '0;
    logic       i_s_tlast = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;
    logic       o_m_tuser;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int bytes_sent = 0;
    int burst_left = 0;
    bit hold_request = 1'b0;

    always #5 i_clk = ~i_clk;

    lzss_compressor uut (.*);

    lzss_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tlast(o_m_tlast), .i_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: a randomly drawn mode sets the stall density; one long hold-off on request.
    int rx_cycle = 0;
    int rx_mode = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
        if (hold_request && !hold_done) begin
            hold_cnt <= 30000;
            hold_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
        if (hold_cnt > 1 || (hold_request && !hold_done)) i_m_tready <= 1'b0;
        else if (rx_mode == 0) i_m_tready <= 1'b1;
        else if (rx_mode == 1) i_m_tready <= ($urandom_range(0, 3) != 0);
        else i_m_tready <= ($urandom_range(0, 3) == 0);
    end

    task automatic send_byte(logic [7:0] b, logic is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        i_s_tlast <= is_last;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
    endtask

    // Waits for the stream to drain and for the clearing pass behind it.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (lzc_pkg::WINDOW_SIZE_DEF + 100) @(posedge i_clk);
    endtask

    task automatic write_fill(logic [7:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_stream(int len, int alphabet);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            // A narrow alphabet gives long matches; a wide one gives literals.
            b = (alphabet == 0) ? 8'($urandom) : 8'($urandom_range(0, alphabet)) + 8'h40;
            send_byte(b, i == len - 1);
        end
    endtask

    initial begin
        int len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes equal to the reset fill match the preset window.
        for (int i = 0; i < 5; i++) send_byte(lzc_pkg::FILL_RESET, i == 4);
        send_byte(8'h00, 1'b1);
        write_fill(8'hFF);
        for (int i = 0; i < 6; i++) send_byte(i[0] ? 8'h55 : 8'hAA, i == 5);
        // The new fill only shows up once the previous stream has been flushed.
        for (int i = 0; i < 4; i++) send_byte(8'hFF, i == 3);
        write_fill(8'h00);
        for (int i = 0; i < 9; i++) send_byte(8'h41 + 8'(i % 3), i == 8);
        wait_drained();

        while (bytes_sent < 140) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8)
                                              : $urandom_range(19, 45);
            if (len > 140 - bytes_sent) len = 140 - bytes_sent;
            if (!hold_request && bytes_sent > 40) hold_request = 1'b1;
            send_stream(len, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4));
            if ($urandom_range(0, 2) == 0) write_fill(8'($urandom));
            else if ($urandom_range(0, 1) == 0) wait_drained();
        end
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (lzc_pkg::WINDOW_SIZE_DEF + 200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
